>>> rtl/brm_pkg.sv
// Package for the byte register machine: payload structs, opcodes, status codes.
// No dependencies.
package brm_pkg;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [6:0]        mem_addr;
    logic signed [7:0] mem_data;
    logic signed [7:0] load_a;
    logic signed [7:0] load_b;
    logic signed [7:0] load_c;
    logic signed [7:0] load_d;
    logic [7:0]        load_pc;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic signed [7:0] reg_a;
    logic signed [7:0] reg_b;
    logic signed [7:0] reg_c;
    logic signed [7:0] reg_d;
    logic [7:0]        prog_counter;
    logic              terminated;
    logic signed [7:0] read_data;
  } rsp_t;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_LOAD  = 2'd2;
  localparam logic [1:0] REQ_STEP  = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_OVF   = 3'd1;
  localparam logic [2:0] ST_UNF   = 3'd2;
  localparam logic [2:0] ST_DIV0  = 3'd3;
  localparam logic [2:0] ST_ILL   = 3'd4;
  localparam logic [2:0] ST_FAULT = 3'd5;
  localparam logic [2:0] ST_UNSUP = 3'd6;

  localparam logic [7:0] OP_RET = 8'h00;
  localparam logic [7:0] OP_MOV = 8'h01;
  localparam logic [7:0] OP_WRI = 8'h02;
  localparam logic [7:0] OP_ADD = 8'h03;
  localparam logic [7:0] OP_SUB = 8'h04;
  localparam logic [7:0] OP_MUL = 8'h05;
  localparam logic [7:0] OP_DIV = 8'h06;
  localparam logic [7:0] OP_MOD = 8'h07;
  localparam logic [7:0] OP_INC = 8'h08;
  localparam logic [7:0] OP_DEC = 8'h09;
  localparam logic [7:0] OP_JUM = 8'h0A;
  localparam logic [7:0] OP_IFS = 8'h0B;
  localparam logic [7:0] OP_IFE = 8'h0C;
  localparam logic [7:0] OP_IFB = 8'h0D;
  localparam logic [7:0] OP_IFN = 8'h0E;
  localparam logic [7:0] OP_SYS_LO = 8'h0F;
  localparam logic [7:0] OP_SYS_HI = 8'h19;
  localparam logic [7:0] OP_NOP = 8'hFF;

  localparam logic CFG_UPPER = 1'b0;
  localparam logic CFG_LOWER = 1'b1;

endpackage

>>> rtl/byte_register_machine_step.sv
// Byte register machine: request sequencer, register file, iterative divider.
// Depends on brm_pkg and brm_ram.
//
// Usage: requests enter on in_valid/in_stall as brm_pkg::req_t, one at a time;
// each gives exactly one brm_pkg::rsp_t on out_valid/out_stall. in_stall is high
// while a request is in work or its response waits. A memory write, context
// load or out-of-range access goes from S_DONE to S_OUT once taken; a memory
// read passes through S_RD and S_RDW first. A step fetches its opcode and
// operand bytes and reads its memory operands, all through the single RAM
// port; DIV/MOD add 8 restoring divide iterations and a state to apply the
// signs. Each request holds the port until its response is taken.
// A result is written back only when the step finishes without error.
// Configuration writes (cfg_we, cfg_index, cfg_data) set the upper and lower
// bounds and must occur while idle.
// Reset clears registers and PC, sets bounds to 127/-128; memory contents are
// undefined until written. A stalled response holds until taken; no new
// request is accepted meanwhile.
module byte_register_machine_step #(
  parameter int MEM_DEPTH = 128
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  brm_pkg::req_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output brm_pkg::rsp_t   out_data,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_data
);
  localparam int AW = $clog2(MEM_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_RDW   = 4'd2;
  localparam logic [3:0] S_OP    = 4'd3;
  localparam logic [3:0] S_LOCA  = 4'd4;
  localparam logic [3:0] S_VALA  = 4'd5;
  localparam logic [3:0] S_LOCB  = 4'd6;
  localparam logic [3:0] S_VALB  = 4'd7;
  localparam logic [3:0] S_IMM   = 4'd8;
  localparam logic [3:0] S_EXEC  = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;
  localparam logic [3:0] S_FETCH = 4'd13;

  logic [3:0] state, ret_state;
  logic [6:0] upper_bound;
  logic signed [7:0] lower_bound;
  logic signed [7:0] acc [4];
  logic [7:0] pc, pcw;
  brm_pkg::req_t req;
  logic [7:0] op;
  logic [8:0] loca;   // [8]=memory, [7:0] reg index or address
  logic signed [7:0] va, vb, imm;
  logic [2:0] st;
  logic term;
  logic signed [7:0] rd;
  logic vb_mem;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0] ram_wdata, ram_rdata;
  logic [AW-1:0] rd_addr;

  brm_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // divider
  logic [7:0] dq, dr, dd;
  logic [3:0] dcnt;
  logic [8:0] dtrial;
  logic [7:0] mag_a, mag_b;
  assign mag_a = va[7] ? 8'(-va) : 8'(va);
  assign mag_b = vb[7] ? 8'(-vb) : 8'(vb);
  assign dtrial = {dr, dq[7]} - {1'b0, dd};

  logic signed [7:0] wval;
  logic wr_mem;
  logic [AW-1:0] wr_addr;

  logic signed [15:0] prod;
  logic signed [7:0] fb;
  assign fb = $signed(ram_rdata);
  assign prod = va * vb;

  function automatic logic [2:0] bchk(input logic signed [15:0] v,
                                      input logic [6:0] ub, input logic signed [7:0] lb);
    if (v > $signed({9'd0, ub})) begin
      return brm_pkg::ST_OVF;
    end else if (v < 16'(lb)) begin
      return brm_pkg::ST_UNF;
    end
    return brm_pkg::ST_OK;
  endfunction

  logic pc_ok;
  assign pc_ok = (32'(pcw) < MEM_DEPTH);
  logic byte_is_reg, byte_is_mem;
  assign byte_is_reg = (fb >= -8'sd4) && (fb <= -8'sd1);
  assign byte_is_mem = !fb[7] && (32'(ram_rdata) < MEM_DEPTH);

  always_comb begin
    ram_we = 1'b0;
    ram_wdata = 8'(wval);
    ram_addr = rd_addr;
    if (state == S_FETCH) begin
      ram_addr = AW'(pcw);
    end
    if (state == S_DONE && wr_mem && st == brm_pkg::ST_OK) begin
      ram_we = 1'b1;
      ram_addr = wr_addr;
    end
  end

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      upper_bound <= 7'd127;
      lower_bound <= -8'sd128;
      for (int i = 0; i < 4; i++) acc[i] <= 8'sd0;
      pc <= 8'd0;
      wr_mem <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == brm_pkg::CFG_UPPER) upper_bound <= cfg_data[6:0];
        else lower_bound <= $signed(cfg_data);
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            st <= brm_pkg::ST_OK;
            term <= 1'b0;
            rd <= 8'sd0;
            wr_mem <= 1'b0;
            pcw <= pc;
            case (in_data.req_type)
              brm_pkg::REQ_WRITE: begin
                if (32'(in_data.mem_addr) < MEM_DEPTH) begin
                  wr_mem <= 1'b1;
                  wr_addr <= AW'(in_data.mem_addr);
                  wval <= in_data.mem_data;
                end else st <= brm_pkg::ST_FAULT;
                state <= S_DONE;
              end
              brm_pkg::REQ_READ: begin
                if (32'(in_data.mem_addr) < MEM_DEPTH) begin
                  rd_addr <= AW'(in_data.mem_addr);
                  state <= S_RD;
                end else begin
                  st <= brm_pkg::ST_FAULT;
                  state <= S_DONE;
                end
              end
              brm_pkg::REQ_LOAD: begin
                acc[0] <= in_data.load_a;
                acc[1] <= in_data.load_b;
                acc[2] <= in_data.load_c;
                acc[3] <= in_data.load_d;
                pc <= in_data.load_pc;
                state <= S_DONE;
              end
              default: begin
                ret_state <= S_OP;
                state <= S_FETCH;
              end
            endcase
          end
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          rd <= fb;
          state <= S_DONE;
        end
        S_FETCH: begin
          if (pc_ok) begin
            pcw <= pcw + 8'd1;
            state <= ret_state;
          end else begin
            st <= brm_pkg::ST_FAULT;
            state <= S_DONE;
          end
        end
        S_OP: begin
          op <= ram_rdata;
          state <= S_DONE;
          if (ram_rdata == brm_pkg::OP_RET) term <= 1'b1;
          else if (ram_rdata == brm_pkg::OP_NOP) begin
          end else if (ram_rdata >= brm_pkg::OP_SYS_LO && ram_rdata <= brm_pkg::OP_SYS_HI)
            st <= brm_pkg::ST_UNSUP;
          else if (ram_rdata > brm_pkg::OP_SYS_HI) st <= brm_pkg::ST_ILL;
          else if (ram_rdata == brm_pkg::OP_JUM) begin
            ret_state <= S_IMM;
            state <= S_FETCH;
          end else begin
            ret_state <= S_LOCA;
            state <= S_FETCH;
          end
        end
        S_LOCA, S_LOCB: begin
          if (byte_is_reg) begin
            if (state == S_LOCA) begin
              loca <= {1'b0, 8'(-fb - 8'sd1)};
              va <= acc[2'(-fb - 8'sd1)];
            end else vb <= acc[2'(-fb - 8'sd1)];
            state <= (state == S_LOCA) ? S_VALA : S_VALB;
            ret_state <= S_IDLE;
          end else if (byte_is_mem) begin
            if (state == S_LOCA) loca <= {1'b1, ram_rdata};
            rd_addr <= AW'(ram_rdata);
            ret_state <= S_RD;
            state <= (state == S_LOCA) ? S_VALA : S_VALB;
          end else begin
            st <= brm_pkg::ST_FAULT;
            state <= S_DONE;
          end
        end
        S_VALA, S_VALB: begin
          // ret_state==S_RD marks a memory operand whose read data is not yet valid
          if (ret_state == S_RD) begin
            ret_state <= S_IDLE;
          end else begin
            if (state == S_VALA) begin
              if (loca[8]) va <= fb;
              if (op == brm_pkg::OP_INC || op == brm_pkg::OP_DEC) state <= S_EXEC;
              else if (op == brm_pkg::OP_WRI || op >= brm_pkg::OP_IFS) begin
                ret_state <= S_IMM;
                state <= S_FETCH;
              end else begin
                ret_state <= S_LOCB;
                state <= S_FETCH;
              end
            end else begin
              if (ret_state == S_IDLE && vb_mem) vb <= fb;
              state <= S_EXEC;
            end
          end
        end
        S_IMM: begin
          imm <= fb;
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_DONE;
          wr_mem <= loca[8];
          wr_addr <= AW'(loca[7:0]);
          case (op)
            brm_pkg::OP_JUM: begin wr_mem <= 1'b0; pcw <= 8'(imm); end
            brm_pkg::OP_WRI: wval <= imm;
            brm_pkg::OP_IFS: begin wr_mem <= 1'b0; if (va < 0) pcw <= 8'(imm); end
            brm_pkg::OP_IFE: begin wr_mem <= 1'b0; if (va == 0) pcw <= 8'(imm); end
            brm_pkg::OP_IFB: begin wr_mem <= 1'b0; if (va > 0) pcw <= 8'(imm); end
            brm_pkg::OP_IFN: begin wr_mem <= 1'b0; if (va != 0) pcw <= 8'(imm); end
            brm_pkg::OP_MOV: wval <= vb;
            brm_pkg::OP_ADD: begin
              wval <= va + vb;
              st <= bchk(16'(va) + 16'(vb), upper_bound, lower_bound);
            end
            brm_pkg::OP_SUB: begin
              wval <= va - vb;
              st <= bchk(16'(va) - 16'(vb), upper_bound, lower_bound);
            end
            brm_pkg::OP_MUL: begin
              wval <= prod[7:0];
              st <= bchk(prod, upper_bound, lower_bound);
            end
            brm_pkg::OP_INC: begin
              wval <= va + 8'sd1;
              st <= bchk(16'(va) + 16'sd1, upper_bound, lower_bound);
            end
            brm_pkg::OP_DEC: begin
              wval <= va - 8'sd1;
              st <= bchk(16'(va) - 16'sd1, upper_bound, lower_bound);
            end
            default: begin
              if (vb == 0) st <= brm_pkg::ST_DIV0;
              else begin
                dq <= mag_a;
                dr <= 8'd0;
                dd <= mag_b;
                dcnt <= 4'd8;
                state <= S_DIV;
              end
            end
          endcase
        end
        S_DIV: begin
          if (dcnt != 4'd0) begin
            dcnt <= dcnt - 4'd1;
            if (!dtrial[8]) begin
              dr <= dtrial[7:0];
              dq <= {dq[6:0], 1'b1};
            end else begin
              dr <= {dr[6:0], dq[7]};
              dq <= {dq[6:0], 1'b0};
            end
          end else begin
            if (op == brm_pkg::OP_DIV) wval <= (va[7] ^ vb[7]) ? $signed(8'(-dq)) : $signed(dq);
            else wval <= va[7] ? $signed(8'(-dr)) : $signed(dr);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (req.req_type == brm_pkg::REQ_STEP) begin
            if (st == brm_pkg::ST_OK) begin
              pc <= pcw;
              if (!wr_mem && op != brm_pkg::OP_JUM && op != brm_pkg::OP_RET &&
                  op != brm_pkg::OP_NOP && op < brm_pkg::OP_IFS)
                acc[loca[1:0]] <= wval;
            end else term <= 1'b0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // B operand memory flag
  always_ff @(posedge clk) begin
    if (state == S_LOCB) vb_mem <= byte_is_mem && !byte_is_reg;
  end

  always_comb begin
    out_data.status = st;
    out_data.reg_a = acc[0];
    out_data.reg_b = acc[1];
    out_data.reg_c = acc[2];
    out_data.reg_d = acc[3];
    out_data.prog_counter = pc;
    out_data.terminated = term;
    out_data.read_data = rd;
  end

  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("accept while response pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("response changed under stall");
  a_term: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.terminated |-> out_data.status == brm_pkg::ST_OK)
    else $error("terminated with error");
  a_rd: assert property (@(posedge clk) disable iff (rst)
    out_valid && req.req_type != brm_pkg::REQ_READ |-> out_data.read_data == 8'sd0)
    else $error("read data on non-read");
endmodule

>>> rtl/brm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module brm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
